FILE: rtl/rissd_pkg.sv
// ----------------------------------------------------------------------------
// rissd_pkg
// Shared types and constants for the I/O page soft-switch decoder.
// ----------------------------------------------------------------------------
package rissd_pkg;

  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdKey   = 2'd2;

  localparam logic [15:0] AddrKbdClr  = 16'hC010;
  localparam logic [15:0] AddrIoEnd   = 16'hD000;
  localparam logic [15:0] AddrDisp    = 16'hC050;
  localparam logic [15:0] AddrPlayA   = 16'hC060;
  localparam logic [15:0] AddrPlayB   = 16'hC068;
  localparam logic [15:0] AddrRomBank = 16'hC800;
  localparam logic [15:0] AddrRomRel  = 16'hCFFF;
  localparam logic [7:0]  KeyStrobe   = 8'h80;
  localparam logic [7:0]  KeyMask     = 8'b0111_1111;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY,
    OP_LATCH,
    OP_KBD_CLR,
    OP_REC,
    OP_DISP,
    OP_PLAY,
    OP_CARD,
    OP_ROM,
    OP_ROM_REL
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [2:0] slot;
    logic [3:0] sub;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic       swap;
    logic [2:0] rom_slot;
    logic [3:0] card_register;
    logic [2:0] card_slot;
    logic       card_call;
    logic       cassette_play;
    logic       cassette_record;
    logic       display_changed;
    logic [3:0] display_flags;
    logic       latch_hit;
    logic [7:0] read_data;
  } result_t;

endpackage

FILE: rtl/rissd_front.sv
// ----------------------------------------------------------------------------
// rissd_front
// Classifies one bus word into a soft-switch operation.
// ----------------------------------------------------------------------------
module rissd_front
  import rissd_pkg::*;
(
  input  logic [1:0]  cmd_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output op_t         op_o
);

  op_e kind;

  always_comb begin
    kind = OP_NONE;
    unique case (cmd_i)
      CmdKey: begin
        kind = OP_KEY;
      end
      CmdRead, CmdWrite: begin
        if (address_i[15:4] == 12'hC00) begin
          kind = OP_LATCH;
        end else if (address_i[15:4] == AddrKbdClr[15:4]) begin
          kind = OP_KBD_CLR;
        end else if (address_i[15:4] == 12'hC02) begin
          kind = OP_REC;
        end else if (address_i[15:3] == AddrDisp[15:3]) begin
          kind = OP_DISP;
        end else if (address_i == AddrPlayA || address_i == AddrPlayB) begin
          kind = OP_PLAY;
        end else if (address_i[15:7] == 9'h181) begin
          kind = OP_CARD;
        end else if (address_i[15:11] == 5'b11000 && address_i[10:8] != 3'd0) begin
          kind = OP_ROM;
        end else if (address_i == AddrRomRel) begin
          kind = OP_ROM_REL;
        end
      end
      default: begin
        kind = OP_NONE;
      end
    endcase
  end

  always_comb begin
    op_o.kind = kind;
    op_o.slot = (kind == OP_ROM) ? address_i[10:8] : address_i[6:4];
    op_o.sub  = address_i[3:0];
    op_o.data = data_i;
  end

endmodule

FILE: rtl/rissd_queue.sv
// ----------------------------------------------------------------------------
// rissd_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module rissd_queue
  import rissd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output op_t  pop_op_o
);

  op_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o   = (cnt_q == QueueCntW'(QueueDepth));
  assign avail_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && avail_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: rtl/rissd_back.sv
// ----------------------------------------------------------------------------
// rissd_back
// Applies queued operations to the switch state and registers the result.
// ----------------------------------------------------------------------------
module rissd_back
  import rissd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  op_t     op_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic [7:0] key_q, key_d;
  logic [3:0] disp_q, disp_d;
  logic [7:0] dev_q, dev_d;
  logic [7:0] strobe_q, strobe_d;
  logic [2:0] owner_q, owner_d;
  logic       out_valid_q;
  result_t    out_q, res;
  logic [1:0] disp_bit;
  logic       disp_val;

  assign pop_o       = avail_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign disp_bit    = op_i.sub[2:1];
  // mixed is set by the odd switch, the others by the even one
  assign disp_val    = (disp_bit == 2'd1) ? op_i.sub[0] : !op_i.sub[0];

  always_comb begin
    key_d    = key_q;
    disp_d   = disp_q;
    dev_d    = dev_q;
    strobe_d = strobe_q;
    owner_d  = owner_q;
    res      = '0;
    case (op_i.kind)
      OP_KEY: begin
        key_d = op_i.data | KeyStrobe;
      end
      OP_LATCH: begin
        res.latch_hit = 1'b1;
        res.read_data = key_q;
      end
      OP_KBD_CLR: begin
        key_d = key_q & KeyMask;
      end
      OP_REC: begin
        res.cassette_record = 1'b1;
      end
      OP_DISP: begin
        disp_d[disp_bit]    = disp_val;
        res.display_changed = (disp_bit == 2'd0) || (disp_bit == 2'd3);
      end
      OP_PLAY: begin
        res.cassette_play = 1'b1;
      end
      OP_CARD: begin
        if (dev_q[op_i.slot] || strobe_q[op_i.slot]) begin
          res.card_call     = 1'b1;
          res.card_slot     = op_i.slot;
          res.card_register = op_i.sub;
        end else begin
          dev_d[op_i.slot] = 1'b1;
        end
      end
      OP_ROM: begin
        if (dev_q[op_i.slot] && !strobe_q[op_i.slot]) begin
          strobe_d[owner_q]   = 1'b0;
          strobe_d[op_i.slot] = 1'b1;
          owner_d             = op_i.slot;
          res.swap            = 1'b1;
        end
      end
      OP_ROM_REL: begin
        dev_d[7:1] = '0;
      end
      default: begin
      end
    endcase
    res.display_flags = disp_d;
    res.rom_slot      = owner_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      disp_q      <= '0;
      dev_q       <= '0;
      strobe_q    <= '0;
      owner_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        key_q    <= key_d;
        disp_q   <= disp_d;
        dev_q    <= dev_d;
        strobe_q <= strobe_d;
        owner_q  <= owner_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(strobe_q))
    else $error("more than one slot holds the I/O strobe");

  a_strobe_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q != '0) |-> strobe_q[owner_q])
    else $error("I/O strobe set on a slot that does not own the ROM bank");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped operation left no result word");

  a_swap_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.swap) |-> (out_q.rom_slot != 3'd0))
    else $error("ROM bank swapped to slot zero");
`endif

endmodule

FILE: rtl/retro_io_soft_switch_decoder.sv
// ----------------------------------------------------------------------------
// retro_io_soft_switch_decoder
// I/O page soft-switch decoder: keyboard latch, display flags, slot select.
// ----------------------------------------------------------------------------
// channel   dir  word                          accept
// s_axis    in   tuser cmd, tdata address/data tvalid & tready
// m_axis    out  tdata result fields           tvalid & tready
//
// One word per cycle sustained while m_axis accepts; a word reaches m_axis
// after acceptance through the queue write and then the result register.
// The back end updates switch state as it pops each word, so words chain directly.
// s_axis stalls only when the two-entry queue is full.
// Reset clears all switch state; no clearing pass is needed.
module retro_io_soft_switch_decoder
  import rissd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // address[15:0], data[23:16], zero
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // read_data[7:0], latch_hit[8],
                                       // display_flags[12:9], display_changed[13],
                                       // cassette_record[14], cassette_play[15],
                                       // card_call[16], card_slot[19:17],
                                       // card_register[23:20], rom_slot[26:24],
                                       // rom_swap[27], zero
);

  op_t     front_op, queue_op;
  logic    queue_full, queue_avail, pop;
  result_t res;

  rissd_front u_front (
    .cmd_i     (s_axis_tuser_i),
    .address_i (s_axis_tdata_i[15:0]),
    .data_i    (s_axis_tdata_i[23:16]),
    .op_o      (front_op)
  );

  assign s_axis_tready_o = !queue_full;

  rissd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (s_axis_tvalid_i),
    .push_op_i (front_op),
    .full_o    (queue_full),
    .pop_i     (pop),
    .avail_o   (queue_avail),
    .pop_op_o  (queue_op)
  );

  rissd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (queue_avail),
    .op_i        (queue_op),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {4'd0, res};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for retro_io_soft_switch_decoder. A scoreboard keeps its
// own copy of the keyboard latch, display flags, slot select/strobe bits and
// ROM owner, predicts one result word per accepted bus access and compares
// every returned word field by field. Directed accesses cover each switch;
// random slot sessions and mixed traffic follow, with random gaps on both
// streams, a gap-free stretch and a long sink stall that backs up the input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rissd_pkg::*;

  localparam logic [1:0]  CmdUnused = 2'd3;
  localparam logic [15:0] AddrKbd   = 16'hC000;
  localparam logic [15:0] AddrRec   = 16'hC020;
  localparam logic [15:0] AddrRecEnd = 16'hC030;
  localparam logic [15:0] AddrSlotIo = 16'hC080;
  localparam logic [15:0] AddrSlotRom = 16'hC100;
  localparam int unsigned NumItems  = 450;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 200;

  class switch_scoreboard;
    logic [7:0] key_latch;
    logic [3:0] disp_mode;
    logic [7:0] dev_sel;
    logic [7:0] io_strobe;
    logic [2:0] rom_owner;
    result_t    pending_results[$];
    int unsigned errors;

    function new();
      key_latch = '0;
      disp_mode = '0;
      dev_sel   = '0;
      io_strobe = '0;
      rom_owner = '0;
      errors    = 0;
    endfunction

    function void note_access(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
      result_t    r;
      logic [15:0] rel;
      logic [2:0] s;
      r = '0;
      if (cmd == CmdKey) begin
        key_latch = data | KeyStrobe;
      end else if (cmd == CmdRead || cmd == CmdWrite) begin
        if (addr >= AddrKbd && addr < AddrKbdClr) begin
          r.latch_hit = 1'b1;
          r.read_data = key_latch;
        end else if (addr >= AddrKbdClr && addr < AddrIoEnd) begin
          if (addr < AddrRec) begin
            key_latch = key_latch & KeyMask;
          end else if (addr < AddrRecEnd) begin
            r.cassette_record = 1'b1;
          end else if (addr >= AddrDisp && addr < AddrDisp + 16'd8) begin
            case (addr[2:0])
              3'd0: begin disp_mode[0] = 1'b1; r.display_changed = 1'b1; end
              3'd1: begin disp_mode[0] = 1'b0; r.display_changed = 1'b1; end
              3'd2: disp_mode[1] = 1'b0;
              3'd3: disp_mode[1] = 1'b1;
              3'd4: disp_mode[2] = 1'b1;
              3'd5: disp_mode[2] = 1'b0;
              3'd6: begin disp_mode[3] = 1'b1; r.display_changed = 1'b1; end
              default: begin disp_mode[3] = 1'b0; r.display_changed = 1'b1; end
            endcase
          end else if (addr == AddrPlayA || addr == AddrPlayB) begin
            r.cassette_play = 1'b1;
          end else if (addr >= AddrSlotIo && addr < AddrSlotRom) begin
            rel = addr - 16'h0080;
            s   = rel[6:4];
            if (dev_sel[s] || io_strobe[s]) begin
              r.card_call     = 1'b1;
              r.card_slot     = s;
              r.card_register = addr[3:0];
            end else begin
              dev_sel[s] = 1'b1;
            end
          end else if (addr >= AddrSlotRom && addr < AddrRomBank) begin
            s = addr[10:8];
            if (dev_sel[s] && !io_strobe[s]) begin
              io_strobe[rom_owner] = 1'b0;
              rom_owner    = s;
              io_strobe[s] = 1'b1;
              r.swap       = 1'b1;
            end
          end else if (addr == AddrRomRel) begin
            dev_sel[7:1] = '0;
          end
        end
      end
      r.display_flags = disp_mode;
      r.rom_slot      = rom_owner;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      end
    endfunction

    function void check_word(logic [31:0] word);
      result_t e;
      result_t a;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, word);
        return;
      end
      e = pending_results.pop_front();
      a = result_t'(word[27:0]);
      cmp("read_data", e.read_data, a.read_data);
      cmp("latch_hit", e.latch_hit, a.latch_hit);
      cmp("display_flags", e.display_flags, a.display_flags);
      cmp("display_changed", e.display_changed, a.display_changed);
      cmp("cassette_record", e.cassette_record, a.cassette_record);
      cmp("cassette_play", e.cassette_play, a.cassette_play);
      cmp("card_call", e.card_call, a.card_call);
      cmp("card_slot", e.card_slot, a.card_slot);
      cmp("card_register", e.card_register, a.card_register);
      cmp("rom_slot", e.rom_slot, a.rom_slot);
      cmp("rom_swap", e.swap, a.swap);
      cmp("pad", 0, word[31:28]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;

  bit          sender_calm = 1'b0;
  bit          sink_calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;

  switch_scoreboard sb = new();

  retro_io_soft_switch_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),   // address[15:0], data[23:16], zero
    .s_axis_tuser_i  (s_user),   // cmd[1:0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** retro_io_soft_switch_decoder: FAILED **");
      $finish;
    end
  end

  // word monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) sb.note_access(s_user, s_data[15:0], s_data[23:16]);
      if (m_axis_tvalid_o && m_ready) sb.check_word(m_axis_tdata_o);
    end
  end

  // sink: random backpressure plus one long hold
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= sink_calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_access(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] data);
    while (!sender_calm && $urandom_range(99) < 12) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {8'h00, data, addr};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [1:0] pick_bus_cmd();
    if ($urandom_range(99) < 3) return CmdUnused;
    return $urandom_range(1) ? CmdWrite : CmdRead;
  endfunction

  task automatic slot_session();
    logic [2:0] s;
    int unsigned n;
    s = ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
    send_access(pick_bus_cmd(), AddrSlotIo + {9'd0, s, 4'($urandom)}, 8'($urandom));
    send_access(pick_bus_cmd(), {5'b11000, s, 8'($urandom)}, 8'($urandom));
    n = $urandom_range(3, 1);
    repeat (n) begin
      send_access(pick_bus_cmd(), AddrSlotIo + {9'd0, s, 4'($urandom)}, 8'($urandom));
    end
    if ($urandom_range(99) < 30) send_access(pick_bus_cmd(), AddrRomRel, 8'($urandom));
  endtask

  task automatic random_access();
    int unsigned pick;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_access(CmdKey, 16'($urandom), 8'($urandom));
      return;
    end
    if (pick < 22)      a = AddrKbd + 16'($urandom_range(15));
    else if (pick < 28) a = AddrKbdClr + 16'($urandom_range(15));
    else if (pick < 33) a = AddrRec + 16'($urandom_range(15));
    else if (pick < 47) a = AddrDisp + 16'($urandom_range(7));
    else if (pick < 53) a = 16'hC060 + 16'($urandom_range(15));
    else if (pick < 68) a = AddrSlotIo + 16'($urandom_range(127));
    else if (pick < 80) a = AddrSlotRom + 16'($urandom_range(16'h06FF));
    else if (pick < 85) a = AddrRomRel;
    else if (pick < 90) a = AddrRomBank + 16'($urandom_range(16'h07FF));
    else if (pick < 94) a = 16'hC030 + 16'($urandom_range(16'h001F));
    else                a = 16'($urandom);
    send_access(pick_bus_cmd(), a, 8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_access(CmdRead, AddrKbd, 8'h00);
    send_access(CmdKey, 16'hFFFF, 8'h41);
    send_access(CmdWrite, 16'hC00F, 8'hFF);
    send_access(CmdRead, 16'hC01F, 8'h00);
    send_access(CmdRead, 16'hC005, 8'h00);
    send_access(CmdKey, 16'h0000, 8'hFF);
    send_access(CmdWrite, AddrRec, 8'h00);
    send_access(CmdRead, 16'hC02F, 8'h00);
    for (int i = 0; i < 8; i++) begin
      send_access(i[0] ? CmdWrite : CmdRead, AddrDisp + 16'(i), 8'h00);
    end
    send_access(CmdRead, AddrPlayA, 8'h00);
    send_access(CmdWrite, AddrPlayB, 8'h00);
    send_access(CmdRead, 16'hC0A3, 8'h00);
    send_access(CmdWrite, 16'hC0A5, 8'h5A);
    send_access(CmdRead, 16'hC2FF, 8'h00);
    send_access(CmdWrite, AddrRomRel, 8'h00);
    send_access(CmdUnused, AddrDisp, 8'hFF);
    send_access(CmdWrite, 16'h0000, 8'h00);
    send_access(CmdRead, 16'hFFFF, 8'hFF);

    while (items_sent < NumItems) begin
      if (items_sent >= 150 && items_sent < 260) begin
        sender_calm = 1'b1;
        sink_calm   = 1'b1;
      end else begin
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
      end
      if (items_sent >= 320 && items_sent < 330) begin
        hold_req    = 1'b1;
        sender_calm = 1'b1;
        repeat (24) random_access();
        sender_calm = 1'b0;
      end else if ($urandom_range(99) < 35) begin
        slot_session();
      end else begin
        random_access();
      end
    end
    s_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** retro_io_soft_switch_decoder: PASSED **");
    end else begin
      $display("** retro_io_soft_switch_decoder: FAILED **");
    end
    $finish;
  end

endmodule
